FILE: src/stit_pkg.sv
// Shared types for the session table idle timeout unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package stit_pkg;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned DATE_W  = 23;
    localparam int unsigned TIME_W  = 17;
    localparam int unsigned COUNT_W = 24;
    localparam int unsigned ORDER_W = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MARK_SCAN,
        ST_CHECK,
        ST_BEST_SCAN,
        ST_FETCH,
        ST_EMIT,
        ST_EVICT_FETCH,
        ST_EVICT_EMIT,
        ST_WRITE_HIT,
        ST_WRITE_NEW
    } state_t;

    typedef enum logic [1:0] {
        SCAN_EXPIRE,
        SCAN_FLUSH,
        SCAN_BEST
    } scan_kind_t;

    typedef struct packed {
        logic       load_item;
        logic       scan_start;
        scan_kind_t scan_kind;
        logic       fetch_best;
        logic       fetch_old;
        logic       emit_best;
        logic       emit_evict;
        logic       emit_last;
        logic       write_hit;
        logic       write_new;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic marks_zero;
        logic marks_one;
        logic hit_found;
        logic free_found;
        logic is_flush;
        logic out_full;
    } status_t;

endpackage

FILE: src/session_table_idle_timeout_unit.sv
// Session table idle timeout unit, top level: configuration port and the
// controller and datapath; depends on stit_pkg, stit_ctrl and stit_datapath.
//
// Keeps up to TABLE_ENTRIES open sessions, empty after reset. A request word
// (mode 0) first closes every session idle longer than the configured idle
// period and returns them oldest first, then updates its own session or opens
// one, evicting the oldest (evicted = 1) when the table is full. A flush word
// (mode 1) returns every open session and empties the table. last_of_run
// marks the final result of a word. Each word is handled alone: it is
// accepted and the table memory is scanned once; each closed session then
// costs a decision, a further scan of the table, a fetch and an emit; a
// request ends with a decision and a table write, with a fetch and an emit
// of the oldest session between them when it is evicted, and a flush ends
// with one decision. An emit also waits while the previous result is still
// held. The table memory has a single read port. No clearing pass is needed
// after reset.
module session_table_idle_timeout_unit #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [63:0] user_key,
    input  logic [13:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    input  logic [16:0] time_of_day,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] session_key,
    output logic [13:0] start_year,
    output logic [3:0]  start_month,
    output logic [4:0]  start_day,
    output logic [16:0] first_time,
    output logic [16:0] last_time,
    output logic [16:0] duration,
    output logic [23:0] request_count,
    output logic        evicted,
    output logic        last_of_run
);

    localparam logic [1:0] ADDR_PERIOD = 2'd0;

    logic [stit_pkg::TIME_W-1:0] period_reg;
    stit_pkg::cmd_t              cmd;
    stit_pkg::status_t           status;

    // single register, read at offset zero; a write at any offset updates it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= stit_pkg::TIME_W'(2);
        end
        else if (psel && penable && pwrite)
        begin
            period_reg <= pwdata[stit_pkg::TIME_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_PERIOD) ?
                    {{(32 - stit_pkg::TIME_W){1'b0}}, period_reg} : 32'd0;

    stit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_mode  (mode),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    stit_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .period        (period_reg),
        .mode          (mode),
        .user_key      (user_key),
        .year          (year),
        .month         (month),
        .day           (day),
        .time_of_day   (time_of_day),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .session_key   (session_key),
        .start_year    (start_year),
        .start_month   (start_month),
        .start_day     (start_day),
        .first_time    (first_time),
        .last_time     (last_time),
        .duration      (duration),
        .request_count (request_count),
        .evicted       (evicted),
        .last_of_run   (last_of_run)
    );

endmodule

FILE: src/stit_ctrl.sv
// Controller state machine of the session table idle timeout unit.
// Sequences scans, emits and table writes; depends on stit_pkg.
module stit_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_mode,
    output logic               in_ready,
    input  stit_pkg::status_t  status,
    output stit_pkg::cmd_t     cmd
);

    stit_pkg::state_t state_reg, state_next;
    logic evict_needed;

    assign evict_needed = !status.is_flush && !status.hit_found && !status.free_found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stit_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stit_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stit_pkg::ST_MARK_SCAN;
                end
            end
            stit_pkg::ST_MARK_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = stit_pkg::ST_CHECK;
                end
            end
            stit_pkg::ST_CHECK:
            begin
                if (!status.marks_zero)
                begin
                    state_next = stit_pkg::ST_BEST_SCAN;
                end
                else if (status.is_flush)
                begin
                    state_next = stit_pkg::ST_IDLE;
                end
                else if (status.hit_found)
                begin
                    state_next = stit_pkg::ST_WRITE_HIT;
                end
                else if (status.free_found)
                begin
                    state_next = stit_pkg::ST_WRITE_NEW;
                end
                else
                begin
                    state_next = stit_pkg::ST_EVICT_FETCH;
                end
            end
            stit_pkg::ST_BEST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = stit_pkg::ST_FETCH;
                end
            end
            stit_pkg::ST_FETCH:
            begin
                state_next = stit_pkg::ST_EMIT;
            end
            stit_pkg::ST_EMIT:
            begin
                if (!status.out_full)
                begin
                    state_next = stit_pkg::ST_CHECK;
                end
            end
            stit_pkg::ST_EVICT_FETCH:
            begin
                state_next = stit_pkg::ST_EVICT_EMIT;
            end
            stit_pkg::ST_EVICT_EMIT:
            begin
                if (!status.out_full)
                begin
                    state_next = stit_pkg::ST_WRITE_NEW;
                end
            end
            stit_pkg::ST_WRITE_HIT:
            begin
                state_next = stit_pkg::ST_IDLE;
            end
            stit_pkg::ST_WRITE_NEW:
            begin
                state_next = stit_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = stit_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.scan_kind = stit_pkg::SCAN_EXPIRE;
        in_ready  = 1'b0;
        unique case (state_reg)
            stit_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item  = 1'b1;
                    cmd.scan_start = 1'b1;
                    cmd.scan_kind  = in_mode ? stit_pkg::SCAN_FLUSH : stit_pkg::SCAN_EXPIRE;
                end
            end
            stit_pkg::ST_CHECK:
            begin
                if (!status.marks_zero)
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_kind  = stit_pkg::SCAN_BEST;
                end
            end
            stit_pkg::ST_FETCH:
            begin
                cmd.fetch_best = 1'b1;
            end
            stit_pkg::ST_EMIT:
            begin
                if (!status.out_full)
                begin
                    cmd.emit_best = 1'b1;
                    cmd.emit_last = status.marks_one && !evict_needed;
                end
            end
            stit_pkg::ST_EVICT_FETCH:
            begin
                cmd.fetch_old = 1'b1;
            end
            stit_pkg::ST_EVICT_EMIT:
            begin
                if (!status.out_full)
                begin
                    cmd.emit_evict = 1'b1;
                    cmd.emit_last  = 1'b1;
                end
            end
            stit_pkg::ST_WRITE_HIT:
            begin
                cmd.write_hit = 1'b1;
            end
            stit_pkg::ST_WRITE_NEW:
            begin
                cmd.write_new = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: src/stit_datapath.sv
// Datapath of the session table idle timeout unit: session memories, valid and
// mark bits, the entry scanner and the result register; depends on stit_pkg.
module stit_datapath #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stit_pkg::cmd_t                cmd,
    output stit_pkg::status_t             status,
    input  logic [stit_pkg::TIME_W-1:0]   period,
    input  logic                          mode,
    input  logic [63:0]                   user_key,
    input  logic [13:0]                   year,
    input  logic [3:0]                    month,
    input  logic [4:0]                    day,
    input  logic [16:0]                   time_of_day,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [63:0]                   session_key,
    output logic [13:0]                   start_year,
    output logic [3:0]                    start_month,
    output logic [4:0]                    start_day,
    output logic [16:0]                   first_time,
    output logic [16:0]                   last_time,
    output logic [16:0]                   duration,
    output logic [23:0]                   request_count,
    output logic                          evicted,
    output logic                          last_of_run
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // session memories, one shared read address and one shared write address
    logic [stit_pkg::KEY_W-1:0]   key_mem   [TABLE_ENTRIES];
    logic [stit_pkg::DATE_W-1:0]  date_mem  [TABLE_ENTRIES];
    logic [stit_pkg::TIME_W-1:0]  first_mem [TABLE_ENTRIES];
    logic [stit_pkg::ORDER_W-1:0] order_mem [TABLE_ENTRIES];
    logic [stit_pkg::TIME_W-1:0]  last_mem  [TABLE_ENTRIES];
    logic [stit_pkg::COUNT_W-1:0] count_mem [TABLE_ENTRIES];

    logic [stit_pkg::KEY_W-1:0]   rd_key_reg;
    logic [stit_pkg::DATE_W-1:0]  rd_date_reg;
    logic [stit_pkg::TIME_W-1:0]  rd_first_reg;
    logic [stit_pkg::ORDER_W-1:0] rd_order_reg;
    logic [stit_pkg::TIME_W-1:0]  rd_last_reg;
    logic [stit_pkg::COUNT_W-1:0] rd_count_reg;

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] mark_reg;
    logic [CNT_W-1:0]         mark_cnt_reg;

    logic                         mode_reg;
    logic [stit_pkg::KEY_W-1:0]   key_reg;
    logic [stit_pkg::DATE_W-1:0]  date_reg;
    logic [stit_pkg::TIME_W-1:0]  time_reg;
    logic [stit_pkg::ORDER_W-1:0] next_order_reg;

    stit_pkg::scan_kind_t scan_kind_reg;
    logic                 scan_active_reg;
    logic [IDX_W-1:0]     scan_idx_reg;
    logic                 proc_vld_reg;
    logic [IDX_W-1:0]     proc_idx_reg;

    logic                         hit_found_reg, free_found_reg, old_found_reg, best_found_reg;
    logic [IDX_W-1:0]             hit_idx_reg, free_idx_reg, old_idx_reg, best_idx_reg;
    logic [stit_pkg::ORDER_W-1:0] old_age_reg, best_age_reg;
    logic [stit_pkg::COUNT_W-1:0] hit_count_reg;

    logic                          out_valid_reg;
    logic [stit_pkg::KEY_W-1:0]    out_key_reg;
    logic [stit_pkg::DATE_W-1:0]   out_date_reg;
    logic [stit_pkg::TIME_W-1:0]   out_first_reg, out_last_reg;
    logic [stit_pkg::COUNT_W-1:0]  out_count_reg;
    logic                          out_evicted_reg, out_last_run_reg;

    logic                         rd_en;
    logic [IDX_W-1:0]             rd_addr;
    logic                         p_valid, p_mark, p_expire, p_live;
    logic [stit_pkg::ORDER_W-1:0] p_age;
    logic [stit_pkg::TIME_W:0]    p_limit;
    logic [IDX_W-1:0]             new_slot;
    logic [stit_pkg::COUNT_W-1:0] hit_count_inc;

    always_comb
    begin
        rd_en   = scan_active_reg || cmd.fetch_best || cmd.fetch_old;
        rd_addr = scan_idx_reg;
        if (cmd.fetch_best)
        begin
            rd_addr = best_idx_reg;
        end
        else if (cmd.fetch_old)
        begin
            rd_addr = old_idx_reg;
        end
    end

    always_comb
    begin
        p_valid  = valid_reg[proc_idx_reg];
        p_mark   = mark_reg[proc_idx_reg];
        p_age    = next_order_reg - rd_order_reg;
        p_limit  = {1'b0, rd_last_reg} + {1'b0, period};
        p_expire = p_valid && ({1'b0, time_reg} > p_limit);
        p_live   = p_valid && !p_expire;
        new_slot = free_found_reg ? free_idx_reg : old_idx_reg;
        hit_count_inc = (hit_count_reg == stit_pkg::COUNT_MAX) ?
                        hit_count_reg : hit_count_reg + stit_pkg::COUNT_W'(1);
    end

    // memory read and write ports
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_date_reg  <= date_mem[rd_addr];
            rd_first_reg <= first_mem[rd_addr];
            rd_order_reg <= order_mem[rd_addr];
            rd_last_reg  <= last_mem[rd_addr];
            rd_count_reg <= count_mem[rd_addr];
        end
        if (cmd.write_new)
        begin
            key_mem[new_slot]   <= key_reg;
            date_mem[new_slot]  <= date_reg;
            first_mem[new_slot] <= time_reg;
            order_mem[new_slot] <= next_order_reg;
        end
        if (cmd.write_new || cmd.write_hit)
        begin
            last_mem[cmd.write_hit ? hit_idx_reg : new_slot]  <= time_reg;
            count_mem[cmd.write_hit ? hit_idx_reg : new_slot] <=
                cmd.write_hit ? hit_count_inc : stit_pkg::COUNT_W'(1);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= mode;
            key_reg  <= user_key;
            date_reg <= {year, month, day};
            time_reg <= time_of_day;
        end
        if (proc_vld_reg)
        begin
            unique case (scan_kind_reg)
                stit_pkg::SCAN_EXPIRE:
                begin
                    if (p_live && rd_key_reg == key_reg && !hit_found_reg)
                    begin
                        hit_idx_reg   <= proc_idx_reg;
                        hit_count_reg <= rd_count_reg;
                    end
                    if (!p_live && !free_found_reg)
                    begin
                        free_idx_reg <= proc_idx_reg;
                    end
                    if (p_valid && (!old_found_reg || p_age > old_age_reg))
                    begin
                        old_idx_reg <= proc_idx_reg;
                        old_age_reg <= p_age;
                    end
                end
                stit_pkg::SCAN_BEST:
                begin
                    if (p_mark && (!best_found_reg || p_age > best_age_reg))
                    begin
                        best_idx_reg <= proc_idx_reg;
                        best_age_reg <= p_age;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.emit_best || cmd.emit_evict)
        begin
            out_key_reg      <= rd_key_reg;
            out_date_reg     <= rd_date_reg;
            out_first_reg    <= rd_first_reg;
            out_last_reg     <= rd_last_reg;
            out_count_reg    <= rd_count_reg;
            out_evicted_reg  <= cmd.emit_evict;
            out_last_run_reg <= cmd.emit_last;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            mark_reg        <= '0;
            mark_cnt_reg    <= '0;
            next_order_reg  <= '0;
            scan_kind_reg   <= stit_pkg::SCAN_EXPIRE;
            scan_active_reg <= 1'b0;
            scan_idx_reg    <= '0;
            proc_vld_reg    <= 1'b0;
            proc_idx_reg    <= '0;
            hit_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
            old_found_reg   <= 1'b0;
            best_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            proc_vld_reg <= scan_active_reg;
            proc_idx_reg <= scan_idx_reg;
            if (cmd.scan_start)
            begin
                scan_kind_reg   <= cmd.scan_kind;
                scan_active_reg <= 1'b1;
                scan_idx_reg    <= '0;
                best_found_reg  <= 1'b0;
                if (cmd.scan_kind != stit_pkg::SCAN_BEST)
                begin
                    hit_found_reg  <= 1'b0;
                    free_found_reg <= 1'b0;
                    old_found_reg  <= 1'b0;
                    mark_cnt_reg   <= '0;
                end
            end
            else if (scan_active_reg)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                if (scan_idx_reg == LAST_IDX)
                begin
                    scan_active_reg <= 1'b0;
                end
            end
            if (proc_vld_reg)
            begin
                unique case (scan_kind_reg)
                    stit_pkg::SCAN_EXPIRE:
                    begin
                        mark_reg[proc_idx_reg] <= p_expire;
                        if (p_expire)
                        begin
                            mark_cnt_reg <= mark_cnt_reg + CNT_W'(1);
                        end
                        if (p_live && rd_key_reg == key_reg)
                        begin
                            hit_found_reg <= 1'b1;
                        end
                        if (!p_live)
                        begin
                            free_found_reg <= 1'b1;
                        end
                        if (p_valid)
                        begin
                            old_found_reg <= 1'b1;
                        end
                    end
                    stit_pkg::SCAN_FLUSH:
                    begin
                        mark_reg[proc_idx_reg] <= p_valid;
                        if (p_valid)
                        begin
                            mark_cnt_reg <= mark_cnt_reg + CNT_W'(1);
                        end
                    end
                    stit_pkg::SCAN_BEST:
                    begin
                        if (p_mark)
                        begin
                            best_found_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.emit_best)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
                mark_reg[best_idx_reg]  <= 1'b0;
                mark_cnt_reg            <= mark_cnt_reg - CNT_W'(1);
            end
            if (cmd.write_new)
            begin
                valid_reg[new_slot] <= 1'b1;
            end
            if (cmd.write_new || cmd.write_hit)
            begin
                next_order_reg <= next_order_reg + stit_pkg::ORDER_W'(1);
            end
            // hold the word until taken
            if (cmd.emit_best || cmd.emit_evict)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.scan_done  = proc_vld_reg && (proc_idx_reg == LAST_IDX);
        status.marks_zero = (mark_cnt_reg == '0);
        status.marks_one  = (mark_cnt_reg == CNT_W'(1));
        status.hit_found  = hit_found_reg;
        status.free_found = free_found_reg;
        status.is_flush   = mode_reg;
        status.out_full   = out_valid_reg;
    end

    assign out_valid     = out_valid_reg;
    assign session_key   = out_key_reg;
    assign start_year    = out_date_reg[22:9];
    assign start_month   = out_date_reg[8:5];
    assign start_day     = out_date_reg[4:0];
    assign first_time    = out_first_reg;
    assign last_time     = out_last_reg;
    assign duration      = out_last_reg - out_first_reg + stit_pkg::TIME_W'(1);
    assign request_count = out_count_reg;
    assign evicted       = out_evicted_reg;
    assign last_of_run   = out_last_run_reg;

endmodule
